### rtl/ehc_pkg.sv
package ehc_pkg;

    localparam logic [2:0] KIND_ETH    = 3'd0;
    localparam logic [2:0] KIND_ARP    = 3'd1;
    localparam logic [2:0] KIND_IPV4   = 3'd2;
    localparam logic [2:0] KIND_IPV6   = 3'd3;
    localparam logic [2:0] KIND_ICMPV4 = 3'd4;
    localparam logic [2:0] KIND_TCP    = 3'd5;
    localparam logic [2:0] KIND_UDP    = 3'd6;
    localparam logic [2:0] KIND_END    = 3'd7;

    localparam logic [1:0] NET_NONE = 2'd0;
    localparam logic [1:0] NET_IPV4 = 2'd1;
    localparam logic [1:0] NET_IPV6 = 2'd2;
    localparam logic [1:0] NET_ARP  = 2'd3;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
    localparam logic [15:0] ETYPE_ARP  = 16'h0806;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam int POS_ETYPE_HI = 12;
    localparam int POS_ETYPE_LO = 13;
    localparam int POS_VER_IHL  = 14;
    localparam int POS_TLEN_HI  = 16;
    localparam int POS_TLEN_LO  = 17;
    localparam int POS_V6_NEXT  = 20;
    localparam int POS_V4_PROTO = 23;

    localparam int ETH_BYTES    = 14;
    localparam int V4_DECIDE    = 18;
    localparam int V4_PROTO_IN  = 24;
    localparam int V6_END       = 54;
    localparam int TCP_BYTES    = 20;
    localparam int UDP_BYTES    = 8;
    localparam int ICMP_BYTES   = 8;

    localparam int MAX_RECORDS  = 3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [13:0] offset;
        logic [13:0] length;
    } record_t;

    typedef struct packed {
        logic [1:0] count;
        record_t    rec2;
        record_t    rec1;
        record_t    rec0;
    } bundle_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

### rtl/ehc_front.sv
module ehc_front #(
    parameter int MAX_FRAME_BYTES = 16383
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    output logic             push,
    output ehc_pkg::bundle_t bundle
);

    localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
    localparam int SW = (CW > 8) ? CW : 8;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [15:0]   etype_reg, etype_next;
    logic [3:0]    ver_reg, ver_next;
    logic [3:0]    ihl_reg, ihl_next;
    logic [15:0]   tlen_reg, tlen_next;
    logic [7:0]    proto_reg, proto_next;
    logic [1:0]    net_reg, net_next;
    logic          f_eth_reg, f_eth_next;
    logic          f_dec_reg, f_dec_next;
    logic          f_ok_reg, f_ok_next;
    logic          f_tr_reg, f_tr_next;

    ehc_pkg::record_t recs [ehc_pkg::MAX_RECORDS];
    logic [1:0]       n;
    logic [CW-1:0]    seen;
    logic             v4;
    logic [6:0]       start;
    logic [4:0]       need;
    logic [2:0]       tkind;
    logic [7:0]       ready_at;

    function automatic ehc_pkg::record_t mk(logic [2:0] k, logic [13:0] o, logic [13:0] l);
        ehc_pkg::record_t r;
        r.kind   = k;
        r.offset = o;
        r.length = l;
        return r;
    endfunction

    always_comb begin
        cnt_next   = cnt_reg;
        etype_next = etype_reg;
        ver_next   = ver_reg;
        ihl_next   = ihl_reg;
        tlen_next  = tlen_reg;
        proto_next = proto_reg;
        net_next   = net_reg;
        f_eth_next = f_eth_reg;
        f_dec_next = f_dec_reg;
        f_ok_next  = f_ok_reg;
        f_tr_next  = f_tr_reg;
        n          = 2'd0;
        v4         = 1'b0;
        start      = 7'd0;
        need       = 5'd0;
        tkind      = ehc_pkg::KIND_ETH;
        ready_at   = 8'd0;
        for (int i = 0; i < ehc_pkg::MAX_RECORDS; i++) begin
            recs[i] = mk(ehc_pkg::KIND_ETH, 14'd0, 14'd0);
        end

        if (cnt_reg < CW'(MAX_FRAME_BYTES)) begin
            cnt_next = cnt_reg + 1'b1;
        end
        if (cnt_reg == CW'(ehc_pkg::POS_ETYPE_HI)) etype_next = {data_byte, 8'h00};
        if (cnt_reg == CW'(ehc_pkg::POS_ETYPE_LO)) etype_next = {etype_reg[15:8], data_byte};
        if (cnt_reg == CW'(ehc_pkg::POS_VER_IHL)) begin
            ver_next = data_byte[7:4];
            ihl_next = data_byte[3:0];
        end
        if (cnt_reg == CW'(ehc_pkg::POS_TLEN_HI)) tlen_next = {data_byte, 8'h00};
        if (cnt_reg == CW'(ehc_pkg::POS_TLEN_LO)) tlen_next = {tlen_reg[15:8], data_byte};
        if (cnt_reg == CW'(ehc_pkg::POS_V6_NEXT) && etype_next == ehc_pkg::ETYPE_IPV6) begin
            proto_next = data_byte;
        end
        if (cnt_reg == CW'(ehc_pkg::POS_V4_PROTO) && etype_next == ehc_pkg::ETYPE_IPV4) begin
            proto_next = data_byte;
        end
        seen = cnt_next;

        if (!f_eth_reg && SW'(seen) >= SW'(ehc_pkg::ETH_BYTES)) begin
            f_eth_next = 1'b1;
            recs[n] = mk(ehc_pkg::KIND_ETH, 14'd0, 14'd0);
            n = n + 2'd1;
            if (etype_next == ehc_pkg::ETYPE_IPV4) begin
                net_next = ehc_pkg::NET_IPV4;
            end else if (etype_next == ehc_pkg::ETYPE_IPV6) begin
                net_next = ehc_pkg::NET_IPV6;
            end else if (etype_next == ehc_pkg::ETYPE_ARP) begin
                net_next   = ehc_pkg::NET_ARP;
                f_dec_next = 1'b1;
                f_ok_next  = 1'b1;
                f_tr_next  = 1'b1;
                recs[n] = mk(ehc_pkg::KIND_ARP, 14'(ehc_pkg::ETH_BYTES), 14'd0);
                n = n + 2'd1;
            end else begin
                net_next   = ehc_pkg::NET_NONE;
                f_dec_next = 1'b1;
                f_tr_next  = 1'b1;
            end
        end

        if (f_eth_next && !f_dec_next) begin
            if (net_next == ehc_pkg::NET_IPV4 && SW'(seen) >= SW'(ehc_pkg::V4_DECIDE)) begin
                f_dec_next = 1'b1;
                if (ver_next == 4'd4 && tlen_next > {10'd0, ihl_next, 2'b00}) begin
                    f_ok_next = 1'b1;
                    recs[n] = mk(ehc_pkg::KIND_IPV4, 14'(ehc_pkg::ETH_BYTES), 14'd0);
                    n = n + 2'd1;
                end else begin
                    f_tr_next = 1'b1;
                end
            end else if (net_next == ehc_pkg::NET_IPV6 &&
                         SW'(seen) >= SW'(ehc_pkg::V6_END)) begin
                f_dec_next = 1'b1;
                f_ok_next  = 1'b1;
                recs[n] = mk(ehc_pkg::KIND_IPV6, 14'(ehc_pkg::ETH_BYTES), 14'd0);
                n = n + 2'd1;
            end
        end

        if (f_ok_next && !f_tr_next) begin
            v4    = (net_next == ehc_pkg::NET_IPV4);
            start = v4 ? (7'(ehc_pkg::ETH_BYTES) + {1'b0, ihl_next, 2'b00})
                       : 7'(ehc_pkg::V6_END);
            if (proto_next == ehc_pkg::PROTO_TCP) begin
                need  = 5'(ehc_pkg::TCP_BYTES);
                tkind = ehc_pkg::KIND_TCP;
            end else if (proto_next == ehc_pkg::PROTO_UDP) begin
                need  = 5'(ehc_pkg::UDP_BYTES);
                tkind = ehc_pkg::KIND_UDP;
            end else if (proto_next == ehc_pkg::PROTO_ICMP && v4) begin
                need  = 5'(ehc_pkg::ICMP_BYTES);
                tkind = ehc_pkg::KIND_ICMPV4;
            end
            ready_at = {1'b0, start} + {3'd0, need};
            if (v4 && ready_at < 8'(ehc_pkg::V4_PROTO_IN)) ready_at = 8'(ehc_pkg::V4_PROTO_IN);
            if (v4 && SW'(seen) >= SW'(ehc_pkg::V4_PROTO_IN) &&
                tkind == ehc_pkg::KIND_ETH) begin
                f_tr_next = 1'b1;
            end else if (!v4 && tkind == ehc_pkg::KIND_ETH) begin
                f_tr_next = 1'b1;
            end else if (tkind != ehc_pkg::KIND_ETH && SW'(seen) >= SW'(ready_at)) begin
                f_tr_next = 1'b1;
                recs[n] = mk(tkind, 14'(start), 14'd0);
                n = n + 2'd1;
            end
        end

        if (last_byte) begin
            recs[n] = mk(ehc_pkg::KIND_END, 14'd0, 14'(seen));
            n = n + 2'd1;
            cnt_next   = '0;
            etype_next = '0;
            ver_next   = '0;
            ihl_next   = '0;
            tlen_next  = '0;
            proto_next = '0;
            net_next   = ehc_pkg::NET_NONE;
            f_eth_next = 1'b0;
            f_dec_next = 1'b0;
            f_ok_next  = 1'b0;
            f_tr_next  = 1'b0;
        end
    end

    assign push         = accept && (n != 2'd0);
    assign bundle.count = n;
    assign bundle.rec0  = recs[0];
    assign bundle.rec1  = recs[1];
    assign bundle.rec2  = recs[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            etype_reg <= '0;
            ver_reg   <= '0;
            ihl_reg   <= '0;
            tlen_reg  <= '0;
            proto_reg <= '0;
            net_reg   <= ehc_pkg::NET_NONE;
            f_eth_reg <= 1'b0;
            f_dec_reg <= 1'b0;
            f_ok_reg  <= 1'b0;
            f_tr_reg  <= 1'b0;
        end else if (accept) begin
            cnt_reg   <= cnt_next;
            etype_reg <= etype_next;
            ver_reg   <= ver_next;
            ihl_reg   <= ihl_next;
            tlen_reg  <= tlen_next;
            proto_reg <= proto_next;
            net_reg   <= net_next;
            f_eth_reg <= f_eth_next;
            f_dec_reg <= f_dec_next;
            f_ok_reg  <= f_ok_next;
            f_tr_reg  <= f_tr_next;
        end
    end

endmodule

### rtl/ehc_queue.sv
module ehc_queue #(
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  ehc_pkg::bundle_t wr_data,
    input  logic             pop,
    output ehc_pkg::bundle_t rd_data,
    output ehc_pkg::q_stat_t stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    ehc_pkg::bundle_t mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    fill_reg, fill_next;
    logic             do_push, do_pop;

    assign stat.full  = (fill_reg == NW'(DEPTH));
    assign stat.empty = (fill_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rd_data    = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

### rtl/ehc_emit.sv
module ehc_emit (
    input  logic             aclk,
    input  logic             aresetn,
    input  ehc_pkg::bundle_t head,
    input  ehc_pkg::q_stat_t stat,
    output logic             pop,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // header_offset[13:0], frame_length[27:14]
    output logic [2:0]       m_axis_tuser,   // header_kind[2:0]
    output logic             m_axis_tlast
);

    ehc_pkg::bundle_t cur_reg, cur_next;
    logic [1:0]       idx_reg, idx_next;
    logic             busy_reg, busy_next;
    ehc_pkg::record_t rec;
    logic             last_rec;
    logic             load;

    always_comb begin
        case (idx_reg)
            2'd0:    rec = cur_reg.rec0;
            2'd1:    rec = cur_reg.rec1;
            default: rec = cur_reg.rec2;
        endcase
    end

    assign last_rec = (idx_reg == cur_reg.count - 2'd1);
    assign load     = !busy_reg || (m_axis_tready && last_rec);
    assign pop      = load && !stat.empty;

    always_comb begin
        cur_next  = cur_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (load) begin
            busy_next = !stat.empty;
            idx_next  = 2'd0;
            if (!stat.empty) begin
                cur_next = head;
            end
        end else if (m_axis_tready) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    assign m_axis_tvalid = busy_reg;
    assign m_axis_tdata  = {4'd0, rec.length, rec.offset};
    assign m_axis_tuser  = rec.kind;
    assign m_axis_tlast  = last_rec;

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= 2'd0;
            busy_reg <= 1'b0;
        end else begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

endmodule

### rtl/ethernet_ip_header_classifier_unit.sv
// A record is written into the bundle queue when its byte is accepted, then loaded into
// the ehc_emit output register that drives m_axis. Throughput: one byte per cycle; records
// leave one per cycle while m_axis_tready is high, set by the output stage; a byte may cause
// two or three, and the queue (QUEUE_DEPTH bundles) absorbs them until s_axis_tready drops.
// Reset: synchronous, active low aresetn; clears the frame state, the queue and the output.
module ethernet_ip_header_classifier_unit #(
    parameter int MAX_FRAME_BYTES = 16383,
    parameter int QUEUE_DEPTH     = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // data_byte[7:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,    // header_offset[13:0], frame_length[27:14]
    output logic [2:0]  m_axis_tuser,    // header_kind[2:0]
    output logic        m_axis_tlast
);

    ehc_pkg::bundle_t wr_bundle;
    ehc_pkg::bundle_t rd_bundle;
    ehc_pkg::q_stat_t q_stat;
    logic             accept;
    logic             push;
    logic             pop;

    assign s_axis_tready = !q_stat.full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    ehc_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .data_byte (s_axis_tdata),
        .last_byte (s_axis_tlast),
        .push      (push),
        .bundle    (wr_bundle)
    );

    ehc_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_data (wr_bundle),
        .pop     (pop),
        .rd_data (rd_bundle),
        .stat    (q_stat)
    );

    ehc_emit u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (rd_bundle),
        .stat          (q_stat),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

### tb/ehc_record_checker.sv
`timescale 1ns / 1ps

module ehc_record_checker #(
    parameter int MAX_FRAME_BYTES = 16383
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // data_byte[7:0]
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,    // header_offset[13:0], frame_length[27:14]
    input  logic [2:0]  m_axis_tuser,    // header_kind[2:0]
    input  logic        m_axis_tlast,
    output int          pending,
    output int          fail_count
);

    localparam logic [3:0] FLG_ETH         = 4'b0001;
    localparam logic [3:0] FLG_NET_DECIDED = 4'b0010;
    localparam logic [3:0] FLG_NET_OK      = 4'b0100;
    localparam logic [3:0] FLG_TRANSPORT   = 4'b1000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [13:0] offset;
        logic [13:0] length;
        logic        last;
    } hdr_rec_t;

    hdr_rec_t    expected_records[$];
    logic [13:0] byte_cnt;
    logic [15:0] ether_type;
    logic [3:0]  ip_ver;
    logic [3:0]  ip_ihl;
    logic [15:0] ip_len;
    logic [7:0]  l4_proto;
    logic [1:0]  net_kind;
    logic [3:0]  flags;
    int          errors = 0;

    function automatic hdr_rec_t mk_rec(input logic [2:0] kind, input int off, input int len);
        hdr_rec_t r;
        r.kind   = kind;
        r.offset = 14'(off);
        r.length = 14'(len);
        r.last   = 1'b0;
        return r;
    endfunction

    function void clear_frame_state();
        byte_cnt   = '0;
        ether_type = '0;
        ip_ver     = '0;
        ip_ihl     = '0;
        ip_len     = '0;
        l4_proto   = '0;
        net_kind   = ehc_pkg::NET_NONE;
        flags      = '0;
    endfunction

    function automatic void classify_byte(input logic [7:0] b, input logic eof);
        int         pos;
        int         seen;
        int         start;
        int         need;
        int         ready;
        logic [2:0] tkind;
        logic       found;
        logic       v4;
        hdr_rec_t   run[$];
        pos = byte_cnt;
        if (pos < MAX_FRAME_BYTES) begin
            byte_cnt = 14'(pos + 1);
            case (pos)
                ehc_pkg::POS_ETYPE_HI: ether_type = {b, 8'h00};
                ehc_pkg::POS_ETYPE_LO: ether_type[7:0] = b;
                ehc_pkg::POS_VER_IHL: begin
                    ip_ver = b[7:4];
                    ip_ihl = b[3:0];
                end
                ehc_pkg::POS_TLEN_HI: ip_len = {b, 8'h00};
                ehc_pkg::POS_TLEN_LO: ip_len[7:0] = b;
                default: ;
            endcase
            if (pos == ehc_pkg::POS_V6_NEXT && ether_type == ehc_pkg::ETYPE_IPV6) l4_proto = b;
            if (pos == ehc_pkg::POS_V4_PROTO && ether_type == ehc_pkg::ETYPE_IPV4) l4_proto = b;
        end
        seen = byte_cnt;

        if ((flags & FLG_ETH) == '0 && seen >= ehc_pkg::ETH_BYTES) begin
            flags |= FLG_ETH;
            run = {run, mk_rec(ehc_pkg::KIND_ETH, 0, 0)};
            if (ether_type == ehc_pkg::ETYPE_IPV4) begin
                net_kind = ehc_pkg::NET_IPV4;
            end else if (ether_type == ehc_pkg::ETYPE_IPV6) begin
                net_kind = ehc_pkg::NET_IPV6;
            end else if (ether_type == ehc_pkg::ETYPE_ARP) begin
                net_kind = ehc_pkg::NET_ARP;
                flags |= FLG_NET_DECIDED | FLG_NET_OK | FLG_TRANSPORT;
                run = {run, mk_rec(ehc_pkg::KIND_ARP, ehc_pkg::ETH_BYTES, 0)};
            end else begin
                net_kind = ehc_pkg::NET_NONE;
                flags |= FLG_NET_DECIDED | FLG_TRANSPORT;
            end
        end

        if ((flags & FLG_ETH) != '0 && (flags & FLG_NET_DECIDED) == '0) begin
            if (net_kind == ehc_pkg::NET_IPV4 && seen >= ehc_pkg::V4_DECIDE) begin
                flags |= FLG_NET_DECIDED;
                if (ip_ver == 4'd4 && int'(ip_len) > int'(ip_ihl) * 4) begin
                    flags |= FLG_NET_OK;
                    run = {run, mk_rec(ehc_pkg::KIND_IPV4, ehc_pkg::ETH_BYTES, 0)};
                end else begin
                    flags |= FLG_TRANSPORT;
                end
            end else if (net_kind == ehc_pkg::NET_IPV6 && seen >= ehc_pkg::V6_END) begin
                flags |= FLG_NET_DECIDED | FLG_NET_OK;
                run = {run, mk_rec(ehc_pkg::KIND_IPV6, ehc_pkg::ETH_BYTES, 0)};
            end
        end

        if ((flags & FLG_NET_OK) != '0 && (flags & FLG_TRANSPORT) == '0) begin
            v4    = (net_kind == ehc_pkg::NET_IPV4);
            start = v4 ? ehc_pkg::ETH_BYTES + int'(ip_ihl) * 4 : ehc_pkg::V6_END;
            need  = 0;
            found = 1'b0;
            tkind = ehc_pkg::KIND_ETH;
            if (l4_proto == ehc_pkg::PROTO_TCP) begin
                need = ehc_pkg::TCP_BYTES; tkind = ehc_pkg::KIND_TCP; found = 1'b1;
            end else if (l4_proto == ehc_pkg::PROTO_UDP) begin
                need = ehc_pkg::UDP_BYTES; tkind = ehc_pkg::KIND_UDP; found = 1'b1;
            end else if (l4_proto == ehc_pkg::PROTO_ICMP && v4) begin
                need = ehc_pkg::ICMP_BYTES; tkind = ehc_pkg::KIND_ICMPV4; found = 1'b1;
            end
            ready = start + need;
            if (v4 && ready < ehc_pkg::V4_PROTO_IN) ready = ehc_pkg::V4_PROTO_IN;
            if (v4 && seen >= ehc_pkg::V4_PROTO_IN && !found) begin
                flags |= FLG_TRANSPORT;
            end else if (!v4 && !found) begin
                flags |= FLG_TRANSPORT;
            end else if (found && seen >= ready) begin
                flags |= FLG_TRANSPORT;
                run = {run, mk_rec(tkind, start, 0)};
            end
        end

        if (eof) begin
            run = {run, mk_rec(ehc_pkg::KIND_END, 0, seen)};
            clear_frame_state();
        end

        if (run.size() > 0) run[run.size() - 1].last = 1'b1;
        expected_records = {expected_records, run};
    endfunction

    always @(posedge aclk) begin
        hdr_rec_t want;
        if (!aresetn) begin
            clear_frame_state();
            expected_records.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_records.size() == 0) begin
                    $error("unexpected record: header_kind %0d header_offset %0d",
                           m_axis_tuser, m_axis_tdata[13:0]);
                    errors += 1;
                end else begin
                    want = expected_records.pop_front();
                    if (m_axis_tuser !== want.kind) begin
                        $error("header_kind: expected %0d, got %0d", want.kind, m_axis_tuser);
                        errors += 1;
                    end
                    if (m_axis_tdata[13:0] !== want.offset) begin
                        $error("header_offset: expected %0d, got %0d",
                               want.offset, m_axis_tdata[13:0]);
                        errors += 1;
                    end
                    if (m_axis_tdata[27:14] !== want.length) begin
                        $error("frame_length: expected %0d, got %0d",
                               want.length, m_axis_tdata[27:14]);
                        errors += 1;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last_in_run: expected %0d, got %0d", want.last, m_axis_tlast);
                        errors += 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) classify_byte(s_axis_tdata, s_axis_tlast);
        end
        pending    <= expected_records.size();
        fail_count <= errors;
    end

endmodule

### tb/tb_ethernet_ip_header_classifier_unit.sv
`timescale 1ns / 1ps

module tb_ethernet_ip_header_classifier_unit;

    localparam int MAX_BYTES   = 16383;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_BYTES = 30;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int pending;
    int fail_count;
    int sender_idle_pct = 34;
    int recv_idle_pct   = 48;
    int cycles          = 0;

    ethernet_ip_header_classifier_unit #(
        .MAX_FRAME_BYTES(MAX_BYTES)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    ehc_record_checker #(
        .MAX_FRAME_BYTES(MAX_BYTES)
    ) u_records (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .pending       (pending),
        .fail_count    (fail_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        cycles        <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eof);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eof;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    task automatic send_frame(input logic [15:0] etype, input logic [3:0] ver,
                              input logic [3:0] ihl, input logic [15:0] tlen,
                              input logic [7:0] proto, input int len);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(255));
            if (i == ehc_pkg::POS_ETYPE_HI) begin
                b = etype[15:8];
            end else if (i == ehc_pkg::POS_ETYPE_LO) begin
                b = etype[7:0];
            end else if (etype == ehc_pkg::ETYPE_IPV4) begin
                if (i == ehc_pkg::POS_VER_IHL) b = {ver, ihl};
                else if (i == ehc_pkg::POS_TLEN_HI) b = tlen[15:8];
                else if (i == ehc_pkg::POS_TLEN_LO) b = tlen[7:0];
                else if (i == ehc_pkg::POS_V4_PROTO) b = proto;
            end else if (etype == ehc_pkg::ETYPE_IPV6 && i == ehc_pkg::POS_V6_NEXT) begin
                b = proto;
            end
            send_byte(b, i == len - 1);
        end
    endtask

    task automatic send_random_frame(input int max_len, output int len);
        int          r;
        int          need;
        int          full;
        logic [15:0] etype;
        logic [3:0]  ver;
        logic [3:0]  ihl;
        logic [15:0] tlen;
        logic [7:0]  proto;
        r    = $urandom_range(99);
        ver  = 4'd4;
        ihl  = 4'd5;
        tlen = 16'($urandom_range(1500, 20));
        case ($urandom_range(3))
            0:       proto = ehc_pkg::PROTO_TCP;
            1:       proto = ehc_pkg::PROTO_UDP;
            2:       proto = ehc_pkg::PROTO_ICMP;
            default: proto = 8'($urandom_range(255));
        endcase
        need = (proto == ehc_pkg::PROTO_TCP) ? ehc_pkg::TCP_BYTES :
               (proto == ehc_pkg::PROTO_UDP) ? ehc_pkg::UDP_BYTES :
               (proto == ehc_pkg::PROTO_ICMP) ? ehc_pkg::ICMP_BYTES : 0;
        if (r < 45) begin
            etype = ehc_pkg::ETYPE_IPV4;
            if ($urandom_range(99) < 15) ver = 4'($urandom_range(15));
            if ($urandom_range(99) < 30) ihl = 4'($urandom_range(15));
            if ($urandom_range(99) < 15) tlen = 16'($urandom_range(int'(ihl) * 4));
            else if ($urandom_range(99) < 10) tlen = 16'($urandom_range(65535));
            full = ehc_pkg::ETH_BYTES + int'(ihl) * 4 + need;
            if (full < ehc_pkg::V4_PROTO_IN) full = ehc_pkg::V4_PROTO_IN;
        end else if (r < 65) begin
            etype = ehc_pkg::ETYPE_IPV6;
            full  = ehc_pkg::V6_END + need;
        end else if (r < 77) begin
            etype = ehc_pkg::ETYPE_ARP;
            full  = ehc_pkg::ETH_BYTES;
        end else begin
            etype = 16'($urandom_range(65535));
            full  = ehc_pkg::ETH_BYTES;
        end
        if ($urandom_range(99) < 70) len = full + int'($urandom_range(8));
        else len = int'($urandom_range(full, 1));
        if (len > max_len) len = max_len;
        send_frame(etype, ver, ihl, tlen, proto, len);
    endtask

    initial begin
        int phase_bytes;
        int frame_len;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_frame(16'h0000, 4'd4, 4'd5, 16'd0, 8'd0, 1);
        send_frame(ehc_pkg::ETYPE_ARP, 4'd4, 4'd5, 16'd0, 8'd0, 14);
        send_frame(16'hFFFF, 4'd4, 4'd5, 16'd40, ehc_pkg::PROTO_TCP, 14);
        send_frame(ehc_pkg::ETYPE_IPV4, 4'd4, 4'd0, 16'd100, ehc_pkg::PROTO_TCP, 34);
        send_frame(ehc_pkg::ETYPE_IPV6, 4'd6, 4'd0, 16'd0, ehc_pkg::PROTO_UDP, 62);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct = 34;
                    recv_idle_pct   = 48;
                end
                1: begin
                    sender_idle_pct = 48;
                    recv_idle_pct   = 34;
                end
                default: begin
                    sender_idle_pct = 0;
                    recv_idle_pct   = 0;
                end
            endcase
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                send_random_frame(PHASE_BYTES - phase_bytes, frame_len);
                phase_bytes += frame_len;
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
